>>> rtl/periodic_timer_table_macros.svh
// ----------------------------------------------------------------------------
// Periodic timer table assertion macros
// Shorthand for clocked implication checks, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_TABLE_MACROS_SVH
`define PERIODIC_TIMER_TABLE_MACROS_SVH

// Same-cycle implication: when a holds, c must hold in the same cycle.
`define PTT_ASSERT_NOW(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("periodic timer table check failed");

// Next-cycle implication: when a holds, c must hold in the next cycle.
`define PTT_ASSERT_NEXT(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("periodic timer table check failed");

`endif

>>> rtl/ptt_pkg.sv
// ----------------------------------------------------------------------------
// Periodic timer table package
// Beat types, event codes and the controller to datapath command and status.
// ----------------------------------------------------------------------------
`default_nettype none

package ptt_pkg;

    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_ELAPSE = 1'b1;

    localparam logic [2:0] EV_FIRED    = 3'd0;
    localparam logic [2:0] EV_FINISHED = 3'd1;
    localparam logic [2:0] EV_ADDED    = 3'd2;
    localparam logic [2:0] EV_FULL     = 3'd3;
    localparam logic [2:0] EV_REPORT   = 3'd4;

    typedef struct packed {
        logic        kind;
        logic [15:0] period;
        logic [15:0] lifetime;
        logic [15:0] elapsed;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  slot;
        logic [2:0]  event_res;
        logic [15:0] next_interval;
        logic        last;
    } res_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       rd;
        logic       place;
        logic       calc;
        logic       fold;
        logic       step;
        logic       emit;
        logic       emit_last;
        logic [2:0] emit_ev;
    } ptt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic kind;
        logic cur_live;
        logic placed;
        logic last_slot;
        logic fire;
        logic fin;
    } ptt_stat_t;

endpackage

`default_nettype wire

>>> rtl/periodic_timer_table.sv
// ----------------------------------------------------------------------------
// Periodic timer table
// A table of periodic timers with add and elapse commands, built as a
// controller and a datapath around one slot memory.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake        Payload        Beat taken when
//   -------   --------------   ------------   ------------------------------
//   command   start / busy     item           start high while busy is low
//   result    strobe           result         every cycle strobe is high
//
// Every item walks all SLOTS slots in order. A free slot takes a scan
// step (and a fold as well where an add item places its timer there); a
// live slot takes a read, an update and a fold into the minimum, plus an
// event beat per fired or finished event. Taking the item and the final
// report come on top of the walk, and the walk through the single-ported
// slot memory sets how long an item takes. Reset clears the live bits at
// once; no clearing pass is needed. The receiver cannot stall: each
// result beat shows for exactly one cycle.
//
`default_nettype none

module periodic_timer_table #(
    parameter int SLOTS     = 8,
    parameter int TIME_BITS = 16
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    output logic                 busy,
    input  ptt_pkg::in_item_t    item,
    output logic                 strobe,
    output ptt_pkg::res_item_t   result
);
    import ptt_pkg::*;

    // The controller only sees status flags; all timer arithmetic and the
    // slot storage live in the datapath.
    ptt_cmd_t  cmd;
    ptt_stat_t stat;

    ptt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // The datapath registers each result beat, so strobe and result change
    // together in the cycle after the controller asks for the event.
    ptt_datapath #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .result (result),
        .strobe (strobe)
    );

endmodule

`default_nettype wire

>>> rtl/ptt_datapath.sv
// ----------------------------------------------------------------------------
// Periodic timer table datapath
// Slot memory, live bits, per-slot update arithmetic, minimum fold and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_datapath #(
    parameter int SLOTS     = 8,
    parameter int TIME_BITS = 16
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  ptt_pkg::in_item_t    item,
    input  ptt_pkg::ptt_cmd_t    cmd,
    output ptt_pkg::ptt_stat_t   stat,
    output ptt_pkg::res_item_t   result,
    output logic                 strobe
);
    import ptt_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int WIDE_W = (TIME_BITS > 16) ? TIME_BITS : 16;
    localparam logic [WIDE_W-1:0]    TIME_MAX_W = WIDE_W'({TIME_BITS{1'b1}});
    localparam logic [TIME_BITS-1:0] TIME_MAX   = {TIME_BITS{1'b1}};
    localparam logic [WIDE_W-1:0]    NI_MAX_W   = WIDE_W'(16'hFFFF);

    typedef struct packed {
        logic [TIME_BITS-1:0] period;
        logic [TIME_BITS-1:0] remaining;
        logic [TIME_BITS-1:0] phase;
    } entry_t;

    function automatic logic [TIME_BITS-1:0] clamp_in(input logic [15:0] v);
        logic [WIDE_W-1:0] w;
        w = WIDE_W'(v);
        if (w > TIME_MAX_W)
        begin
            w = TIME_MAX_W;
        end
        return w[TIME_BITS-1:0];
    endfunction

    function automatic logic [TIME_BITS-1:0] tmin(input logic [TIME_BITS-1:0] a,
                                                  input logic [TIME_BITS-1:0] b);
        return (a < b) ? a : b;
    endfunction

    entry_t                entry_mem [SLOTS];
    entry_t                rdata_reg;
    in_item_t              item_reg;
    logic [SLOT_W-1:0]     idx_reg;
    logic [SLOT_W-1:0]     target_reg;
    logic [SLOTS-1:0]      live_reg;
    logic                  placed_reg;
    logic [TIME_BITS-1:0]  cand_reg;
    logic                  cand_ok_reg;
    logic                  fire_reg;
    logic                  fin_reg;
    logic [TIME_BITS-1:0]  best_reg;
    logic                  any_reg;
    res_item_t             result_reg;
    logic                  strobe_reg;

    logic [WIDE_W-1:0]     el_w;
    logic [WIDE_W-1:0]     rem_w;
    logic [TIME_BITS-1:0]  rem_new;
    logic [WIDE_W:0]       phase_sum;
    logic [TIME_BITS-1:0]  phase_c;
    logic                  fire_c;
    logic                  fin_c;
    logic [TIME_BITS-1:0]  per_c;
    logic [TIME_BITS-1:0]  life_c;
    logic                  is_elapse;
    logic                  mem_we;
    entry_t                mem_wdata;
    logic [WIDE_W-1:0]     best_w;
    logic [15:0]           ni_sat;
    res_item_t             result_next;

    assign is_elapse = (item_reg.kind == KIND_ELAPSE);
    assign per_c     = clamp_in(item_reg.period);
    assign life_c    = clamp_in(item_reg.lifetime);

    // Elapse update of the entry read at the current slot.
    always_comb
    begin
        el_w      = WIDE_W'(item_reg.elapsed);
        rem_w     = WIDE_W'(rdata_reg.remaining);
        rem_new   = (rem_w > el_w) ? TIME_BITS'(rem_w - el_w) : '0;
        phase_sum = {1'b0, WIDE_W'(rdata_reg.phase)} + {1'b0, el_w};
        phase_c   = (phase_sum > {1'b0, TIME_MAX_W}) ? TIME_MAX : TIME_BITS'(phase_sum);
        fire_c    = (phase_c >= rdata_reg.period);
        fin_c     = (rem_new == '0);
    end

    always_comb
    begin
        mem_we    = cmd.place | (cmd.calc & is_elapse);
        mem_wdata = rdata_reg;
        if (cmd.place)
        begin
            mem_wdata.period    = per_c;
            mem_wdata.remaining = life_c;
            mem_wdata.phase     = '0;
        end
        else
        begin
            mem_wdata.remaining = rem_new;
            mem_wdata.phase     = fire_c ? '0 : phase_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[idx_reg] <= mem_wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= entry_mem[idx_reg];
        end
    end

    // Report value: the minimum, held to sixteen bits, or zero with no live slot.
    always_comb
    begin
        best_w = WIDE_W'(best_reg);
        ni_sat = (best_w > NI_MAX_W) ? 16'hFFFF : best_w[15:0];

        result_next.event_res     = cmd.emit_ev;
        result_next.last          = cmd.emit_last;
        result_next.next_interval = (cmd.emit_last && any_reg) ? ni_sat : 16'h0000;
        if (cmd.emit_ev == EV_ADDED)
        begin
            result_next.slot = 3'(target_reg);
        end
        else if (cmd.emit_last)
        begin
            result_next.slot = 3'd0;
        end
        else
        begin
            result_next.slot = 3'(idx_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            live_reg    <= '0;
            placed_reg  <= 1'b0;
            any_reg     <= 1'b0;
            cand_ok_reg <= 1'b0;
            fire_reg    <= 1'b0;
            fin_reg     <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit;
            if (cmd.load)
            begin
                idx_reg    <= '0;
                placed_reg <= 1'b0;
                any_reg    <= 1'b0;
            end
            else if (cmd.step)
            begin
                idx_reg <= idx_reg + SLOT_W'(1);
            end
            if (cmd.place)
            begin
                live_reg[idx_reg] <= 1'b1;
                placed_reg        <= 1'b1;
                cand_ok_reg       <= 1'b1;
                fire_reg          <= 1'b0;
                fin_reg           <= 1'b0;
            end
            else if (cmd.calc)
            begin
                if (is_elapse)
                begin
                    cand_ok_reg <= !fin_c;
                    fire_reg    <= fire_c;
                    fin_reg     <= fin_c;
                    if (fin_c)
                    begin
                        live_reg[idx_reg] <= 1'b0;
                    end
                end
                else
                begin
                    cand_ok_reg <= 1'b1;
                    fire_reg    <= 1'b0;
                    fin_reg     <= 1'b0;
                end
            end
            if (cmd.fold && cand_ok_reg)
            begin
                any_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (cmd.place)
        begin
            target_reg <= idx_reg;
            cand_reg   <= tmin(per_c, life_c);
        end
        else if (cmd.calc)
        begin
            cand_reg <= is_elapse ? tmin(rdata_reg.period, rem_new)
                                  : tmin(rdata_reg.period, rdata_reg.remaining);
        end
        if (cmd.fold && cand_ok_reg && (!any_reg || (cand_reg < best_reg)))
        begin
            best_reg <= cand_reg;
        end
        if (cmd.emit)
        begin
            result_reg <= result_next;
        end
    end

    assign stat.kind      = item_reg.kind;
    assign stat.cur_live  = live_reg[idx_reg];
    assign stat.placed    = placed_reg;
    assign stat.last_slot = (idx_reg == SLOT_W'(SLOTS - 1));
    assign stat.fire      = fire_reg;
    assign stat.fin       = fin_reg;
    assign result         = result_reg;
    assign strobe         = strobe_reg;

endmodule

`default_nettype wire

>>> rtl/ptt_ctrl.sv
// ----------------------------------------------------------------------------
// Periodic timer table controller
// Walks the slots once per item and sequences reads, updates and events.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    output logic                busy,
    input  ptt_pkg::ptt_stat_t  stat,
    output ptt_pkg::ptt_cmd_t   cmd
);
    import ptt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CALC,
        S_FOLD,
        S_FIRE,
        S_FIN,
        S_REPORT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.cur_live)
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_CALC;
                end
                else if ((stat.kind == KIND_ADD) && !stat.placed)
                begin
                    cmd.place  = 1'b1;
                    state_next = S_FOLD;
                end
                else if (stat.last_slot)
                begin
                    state_next = S_REPORT;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            S_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = S_FOLD;
            end
            S_FOLD:
            begin
                cmd.fold = 1'b1;
                if (stat.fire)
                begin
                    state_next = S_FIRE;
                end
                else if (stat.fin)
                begin
                    state_next = S_FIN;
                end
                else if (stat.last_slot)
                begin
                    state_next = S_REPORT;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_FIRE:
            begin
                cmd.emit    = 1'b1;
                cmd.emit_ev = EV_FIRED;
                if (stat.fin)
                begin
                    state_next = S_FIN;
                end
                else if (stat.last_slot)
                begin
                    state_next = S_REPORT;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_FIN:
            begin
                cmd.emit    = 1'b1;
                cmd.emit_ev = EV_FINISHED;
                if (stat.last_slot)
                begin
                    state_next = S_REPORT;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_REPORT:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_last = 1'b1;
                if (stat.kind == KIND_ELAPSE)
                begin
                    cmd.emit_ev = EV_REPORT;
                end
                else if (stat.placed)
                begin
                    cmd.emit_ev = EV_ADDED;
                end
                else
                begin
                    cmd.emit_ev = EV_FULL;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

>>> rtl/ptt_checker.sv
// ----------------------------------------------------------------------------
// Periodic timer table checker
// Port-level checks on command acceptance and result beats, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "periodic_timer_table_macros.svh"

module ptt_checker (
    input wire                 clk,
    input wire                 rst_n,
    input wire                 start,
    input wire                 busy,
    input wire                 strobe,
    input ptt_pkg::res_item_t  result
);
    import ptt_pkg::*;

    // A taken command keeps the block busy for at least the next cycle.
    `PTT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

    // The final beat of an item closes the walk.
    `PTT_ASSERT_NOW(a_last_idle, strobe && result.last, !busy)

    // Slot events come only mid-walk and carry no interval.
    `PTT_ASSERT_NOW(a_event_mid, strobe && !result.last,
        busy && (result.next_interval == 16'h0000) &&
        ((result.event_res == EV_FIRED) || (result.event_res == EV_FINISHED)))

    // Table-full and interval reports name slot zero.
    `PTT_ASSERT_NOW(a_report_slot,
        strobe && ((result.event_res == EV_FULL) || (result.event_res == EV_REPORT)),
        result.last && (result.slot == 3'd0))

endmodule

bind periodic_timer_table ptt_checker u_ptt_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
);

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Periodic timer table testbench
// Sends add and elapse commands and predicts every event beat with a
// behavioural copy of the timer table. Each result beat is checked in order,
// field by field, against the oldest predicted beat.
// ----------------------------------------------------------------------------

module tb_top;

    import ptt_pkg::*;

    localparam int TABLE_SLOTS = 8;

    // ------------------------------------------------------------------------
    // Event predictor and scoreboard.
    //
    // It keeps its own copy of the table: live bits, periods, remaining
    // lifetimes and phases. Every command beat that the block takes is run
    // through the copy, and the event beats that it should cause are queued
    // in order. Each result beat from the block is then compared with the
    // head of that queue.
    // ------------------------------------------------------------------------
    class timer_event_board;
        bit          live        [TABLE_SLOTS];
        logic [15:0] period_of   [TABLE_SLOTS];
        logic [15:0] life_left   [TABLE_SLOTS];
        logic [15:0] phase_of    [TABLE_SLOTS];
        res_item_t   pending_events [$];
        int          mismatches;

        function new();
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                live[i]      = 1'b0;
                period_of[i] = '0;
                life_left[i] = '0;
                phase_of[i]  = '0;
            end
            mismatches = 0;
        endfunction

        // Smallest of period and remaining lifetime over the live slots.
        function logic [15:0] min_interval();
            logic [15:0] best;
            logic [15:0] m;
            bit          any;
            best = '0;
            any  = 1'b0;
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                if (live[i])
                begin
                    m = (period_of[i] < life_left[i]) ? period_of[i] : life_left[i];
                    if (!any || m < best)
                        best = m;
                    any = 1'b1;
                end
            end
            return best;
        endfunction

        function void push_event(int slot_no, logic [2:0] ev_code,
                                 logic [15:0] interval, logic last_flag);
            res_item_t r;
            r.slot          = slot_no[2:0];
            r.event_res     = ev_code;
            r.next_interval = interval;
            r.last          = last_flag;
            pending_events.push_back(r);
        endfunction

        // Run one accepted command beat through the table copy.
        function void take_command(in_item_t cmd);
            logic [16:0] phase_sum;
            int          free_slot;
            if (cmd.kind == KIND_ADD)
            begin
                free_slot = -1;
                for (int i = 0; i < TABLE_SLOTS; i++)
                begin
                    if (!live[i] && free_slot < 0)
                        free_slot = i;
                end
                if (free_slot < 0)
                begin
                    push_event(0, EV_FULL, min_interval(), 1'b1);
                end
                else
                begin
                    live[free_slot]      = 1'b1;
                    period_of[free_slot] = cmd.period;
                    life_left[free_slot] = cmd.lifetime;
                    phase_of[free_slot]  = '0;
                    push_event(free_slot, EV_ADDED, min_interval(), 1'b1);
                end
            end
            else
            begin
                for (int i = 0; i < TABLE_SLOTS; i++)
                begin
                    if (live[i])
                    begin
                        life_left[i] = (life_left[i] > cmd.elapsed) ?
                                       life_left[i] - cmd.elapsed : 16'd0;
                        phase_sum    = {1'b0, phase_of[i]} + {1'b0, cmd.elapsed};
                        phase_of[i]  = phase_sum[16] ? 16'hFFFF : phase_sum[15:0];
                        if (phase_of[i] >= period_of[i])
                        begin
                            push_event(i, EV_FIRED, 16'd0, 1'b0);
                            phase_of[i] = '0;
                        end
                        if (life_left[i] == 16'd0)
                        begin
                            push_event(i, EV_FINISHED, 16'd0, 1'b0);
                            live[i] = 1'b0;
                        end
                    end
                end
                push_event(0, EV_REPORT, min_interval(), 1'b1);
            end
        endfunction

        // Compare one result beat with the oldest predicted event. Beats are
        // printed as slot/event/interval/last.
        function void check_event(res_item_t got);
            res_item_t want;
            if (pending_events.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected beat: %0d/%0d/%0d/%0b",
                             $realtime, got.slot, got.event_res, got.next_interval, got.last);
            end
            else
            begin
                want = pending_events.pop_front();
                if (got.slot !== want.slot || got.event_res !== want.event_res ||
                    got.next_interval !== want.next_interval || got.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: mismatch: want %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                                 $realtime, want.slot, want.event_res, want.next_interval,
                                 want.last, got.slot, got.event_res, got.next_interval,
                                 got.last);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block itself.
    // ------------------------------------------------------------------------
    logic      clk = 1'b0;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_item_t  item;
    logic      strobe;
    res_item_t result;

    timer_event_board board;

    always #10 clk = ~clk;

    periodic_timer_table i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .strobe (strobe),
        .result (result)
    );

    // ------------------------------------------------------------------------
    // Command driver.
    //
    // The sender may first idle for a random gap, which drops start while the
    // block is still walking the table from the previous beat, so the gaps
    // land on every part of the walk. Start is then raised with the new
    // command and held until an edge at which busy is low; that edge takes
    // the beat. Start is left high on return, so back-to-back beats never
    // see it lowered and raised within one time step.
    // ------------------------------------------------------------------------
    task automatic send_command(input in_item_t cmd, input int idle_pct);
        int gap;
        if ($urandom_range(99) < idle_pct)
        begin
            gap   = ($urandom_range(9) == 0) ? $urandom_range(50, 10) : $urandom_range(6, 1);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= cmd;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.take_command(cmd);
    endtask

    function automatic in_item_t make_command(logic kind, logic [15:0] per,
                                              logic [15:0] life, logic [15:0] el);
        in_item_t c;
        c.kind     = kind;
        c.period   = per;
        c.lifetime = life;
        c.elapsed  = el;
        return c;
    endfunction

    // Result monitor: a beat is taken at every edge that ends a strobe cycle.
    always @(posedge clk)
    begin
        if (rst_n && strobe)
            board.check_event(result);
    end

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial
    begin
        in_item_t cmd;
        int       n_live;
        int       add_pct;
        int       idle_pct;
        int       pick;

        board = new();
        rst_n = 1'b0;
        start = 1'b0;
        item  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. An elapse on the empty table reports an interval of
        // zero; a timer with zero period and zero lifetime fires and finishes
        // on the next elapse even when no time has passed.
        send_command(make_command(KIND_ELAPSE, 16'hFFFF, 16'hFFFF, 16'd0), 0);
        send_command(make_command(KIND_ADD, 16'd0, 16'd0, 16'hFFFF), 0);
        send_command(make_command(KIND_ELAPSE, 16'd0, 16'd0, 16'd0), 0);

        // Fill every slot with extreme and ordinary values, then overflow the
        // table once so that the full report appears.
        send_command(make_command(KIND_ADD, 16'd1, 16'd1, 16'd0), 0);
        send_command(make_command(KIND_ADD, 16'hFFFF, 16'hFFFF, 16'h5A5A), 0);
        send_command(make_command(KIND_ADD, 16'd0, 16'd5, 16'd0), 0);
        send_command(make_command(KIND_ADD, 16'd3, 16'hFFFF, 16'd0), 0);
        send_command(make_command(KIND_ADD, 16'hFFFF, 16'd2, 16'd0), 0);
        send_command(make_command(KIND_ADD, 16'd7, 16'd30, 16'd0), 0);
        send_command(make_command(KIND_ADD, 16'h8000, 16'h7FFF, 16'd0), 0);
        send_command(make_command(KIND_ADD, 16'd2, 16'd9, 16'd0), 0);
        send_command(make_command(KIND_ADD, 16'd4, 16'd4, 16'hFFFF), 0);

        // Elapse with no time, one tick, a few ticks and then the widest
        // step, which pushes the phase into saturation and ends every timer.
        send_command(make_command(KIND_ELAPSE, 16'h1234, 16'hABCD, 16'd0), 0);
        send_command(make_command(KIND_ELAPSE, 16'd0, 16'd0, 16'd1), 0);
        send_command(make_command(KIND_ELAPSE, 16'd0, 16'd0, 16'd3), 0);
        send_command(make_command(KIND_ELAPSE, 16'd0, 16'd0, 16'h8000), 0);
        send_command(make_command(KIND_ADD, 16'hFFFF, 16'hFFFF, 16'd0), 0);
        send_command(make_command(KIND_ELAPSE, 16'd0, 16'd0, 16'hFFFF), 0);
        send_command(make_command(KIND_ELAPSE, 16'hFFFF, 16'hFFFF, 16'hFFFF), 0);

        // Random part, in three phases of sender idling: light, heavy, none.
        // Adds are favoured while the table is nearly empty and elapses while
        // it is nearly full, so the walk mostly runs over populated tables.
        // Small periods, lifetimes and steps keep timers firing and finishing
        // often; a share of full-width values exercises every field bit.
        for (int n = 0; n < 370; n++)
        begin
            idle_pct = (n < 123) ? 30 : ((n < 246) ? 78 : 0);
            n_live   = 0;
            for (int i = 0; i < TABLE_SLOTS; i++)
                n_live += board.live[i];
            add_pct  = 70 - 8 * n_live;

            cmd.kind = ($urandom_range(99) < add_pct) ? KIND_ADD : KIND_ELAPSE;

            pick = $urandom_range(99);
            cmd.period   = (pick < 5) ? 16'd0 :
                           ((pick < 15) ? 16'($urandom) : 16'($urandom_range(40, 1)));
            pick = $urandom_range(99);
            cmd.lifetime = (pick < 5) ? 16'd0 :
                           ((pick < 15) ? 16'($urandom) : 16'($urandom_range(120, 1)));
            pick = $urandom_range(99);
            cmd.elapsed  = (pick < 10) ? 16'd0 :
                           ((pick < 18) ? 16'($urandom) : 16'($urandom_range(25, 1)));

            send_command(cmd, idle_pct);
        end
        start <= 1'b0;

        // Drain: wait for every predicted event, then watch a while longer
        // for stray beats. The watchdog below bounds the wait.
        while (board.pending_events.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        if (board.mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this stimulus.
    initial
    begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
